@@ design/dtsu_pkg.sv @@
// Shared types, constants and helpers of the density target stencil update block
`timescale 1ns / 1ps
package dtsu_pkg;

   // Q1.FRAC_BITS densities and targets
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int SUM_W     = VAL_W + 1;
   localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

   localparam int TILE_W = 6;
   localparam int CMD_W  = 2;
   localparam int DIM_W  = 7;

   localparam int GRID_X_MAX_DEF = 64;
   localparam int GRID_Y_MAX_DEF = 64;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INIT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_DENS_FLOOR        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DENS_CAP          = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STEP_LIMIT        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FILL_MARGIN       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_GRADIENT_HEADROOM = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT       = 3'd6;

   // neighbor slots in the in-grid mask
   localparam int NBR_EAST  = 0;
   localparam int NBR_WEST  = 1;
   localparam int NBR_SOUTH = 2;
   localparam int NBR_NORTH = 3;
   localparam int NBR_N     = 4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TILE_W-1:0] tile_x;
      logic [TILE_W-1:0] tile_y;
      logic [VAL_W-1:0]  density;
      logic [NBR_N-1:0]  nbr_ok;
   } item_type;

   // saturated and clamped register values as the datapath uses them
   typedef struct packed {
      logic [VAL_W-1:0] dens_floor;
      logic [VAL_W-1:0] dens_cap;
      logic [VAL_W-1:0] step_limit;
      logic [VAL_W-1:0] fill_margin;
      logic [VAL_W-1:0] gradient_headroom;
      logic [VAL_W-1:0] floor_target;
      logic [DIM_W-1:0] grid_width;
      logic [DIM_W-1:0] grid_height;
   } cfg_type;

   function automatic logic [VAL_W-1:0] sat_frac(input logic [VAL_W-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

endpackage

@@ design/dtsu_ram.sv @@
// Generic one-write one-read RAM with registered read data
`timescale 1ns / 1ps
module dtsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dtsu_csr.sv @@
// Configuration registers with APB-style access and saturated views for the datapath
`timescale 1ns / 1ps
module dtsu_csr import dtsu_pkg::*; #(
   parameter int GRID_X_MAX = GRID_X_MAX_DEF,
   parameter int GRID_Y_MAX = GRID_Y_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [VAL_W-1:0] dens_floor_ff, dens_floor_in;
   logic [VAL_W-1:0] dens_cap_ff, dens_cap_in;
   logic [VAL_W-1:0] step_limit_ff, step_limit_in;
   logic [VAL_W-1:0] fill_margin_ff, fill_margin_in;
   logic [VAL_W-1:0] gradient_headroom_ff, gradient_headroom_in;
   logic [DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [DIM_W-1:0] grid_height_ff, grid_height_in;

   logic                 wr;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [SUM_W-1:0]     base_sum;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (int'(v) > hi) begin
         return DIM_W'(hi);
      end
      return v;
   endfunction

   assign pready  = 1'b1;
   assign wr      = psel & penable & pwrite & pready;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      dens_floor_in        = dens_floor_ff;
      dens_cap_in          = dens_cap_ff;
      step_limit_in        = step_limit_ff;
      fill_margin_in       = fill_margin_ff;
      gradient_headroom_in = gradient_headroom_ff;
      grid_width_in        = grid_width_ff;
      grid_height_in       = grid_height_ff;
      if (wr) begin
         unique case (reg_idx)
            REG_DENS_FLOOR:        dens_floor_in        = pwdata[VAL_W-1:0];
            REG_DENS_CAP:          dens_cap_in          = pwdata[VAL_W-1:0];
            REG_STEP_LIMIT:        step_limit_in        = pwdata[VAL_W-1:0];
            REG_FILL_MARGIN:       fill_margin_in       = pwdata[VAL_W-1:0];
            REG_GRADIENT_HEADROOM: gradient_headroom_in = pwdata[VAL_W-1:0];
            REG_GRID_WIDTH:        grid_width_in        = pwdata[DIM_W-1:0];
            REG_GRID_HEIGHT:       grid_height_in       = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dens_floor_ff        <= '0;
         dens_cap_ff          <= ONE;
         step_limit_ff        <= '0;
         fill_margin_ff       <= '0;
         gradient_headroom_ff <= '0;
         grid_width_ff        <= DIM_W'(64);
         grid_height_ff       <= DIM_W'(64);
      end else begin
         dens_floor_ff        <= dens_floor_in;
         dens_cap_ff          <= dens_cap_in;
         step_limit_ff        <= step_limit_in;
         fill_margin_ff       <= fill_margin_in;
         gradient_headroom_ff <= gradient_headroom_in;
         grid_width_ff        <= grid_width_in;
         grid_height_ff       <= grid_height_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DENS_FLOOR:        prdata = CSR_DATA_W'(dens_floor_ff);
         REG_DENS_CAP:          prdata = CSR_DATA_W'(dens_cap_ff);
         REG_STEP_LIMIT:        prdata = CSR_DATA_W'(step_limit_ff);
         REG_FILL_MARGIN:       prdata = CSR_DATA_W'(fill_margin_ff);
         REG_GRADIENT_HEADROOM: prdata = CSR_DATA_W'(gradient_headroom_ff);
         REG_GRID_WIDTH:        prdata = CSR_DATA_W'(grid_width_ff);
         REG_GRID_HEIGHT:       prdata = CSR_DATA_W'(grid_height_ff);
         default:               prdata = '0;
      endcase
   end

   always_comb begin
      cfg.dens_floor        = sat_frac(dens_floor_ff);
      cfg.dens_cap          = sat_frac(dens_cap_ff);
      cfg.step_limit        = sat_frac(step_limit_ff);
      cfg.fill_margin       = sat_frac(fill_margin_ff);
      cfg.gradient_headroom = sat_frac(gradient_headroom_ff);
      cfg.grid_width        = clamp_dim(grid_width_ff, GRID_X_MAX);
      cfg.grid_height       = clamp_dim(grid_height_ff, GRID_Y_MAX);
      // floor target: density floor plus fill margin, capped at the density cap
      base_sum = SUM_W'(cfg.dens_floor) + SUM_W'(cfg.fill_margin);
      if (base_sum > SUM_W'(cfg.dens_cap)) begin
         cfg.floor_target = cfg.dens_cap;
      end else begin
         cfg.floor_target = base_sum[VAL_W-1:0];
      end
   end

endmodule

@@ design/dtsu_front.sv @@
// Front end: accepts items, drops ignored ones, marks in-grid neighbors, queues the rest
`timescale 1ns / 1ps
module dtsu_front import dtsu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [CMD_W-1:0]  cmd,
   input  logic [TILE_W-1:0] tile_x,
   input  logic [TILE_W-1:0] tile_y,
   input  logic [VAL_W-1:0]  density_in,
   input  cfg_type           cfg,
   output item_type          head,
   output logic              head_valid,
   input  logic              head_pop
);

   localparam int Q_DEPTH = 2;

   item_type   q_ff [Q_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   item_type   cls;
   logic       cls_ok;
   logic       enq;
   logic       deq;

   always_comb begin
      cls.cmd     = cmd;
      cls.tile_x  = tile_x;
      cls.tile_y  = tile_y;
      cls.density = sat_frac(density_in);
      cls.nbr_ok[NBR_EAST]  = (DIM_W'(tile_x) + DIM_W'(1)) < cfg.grid_width;
      cls.nbr_ok[NBR_WEST]  = tile_x != '0;
      cls.nbr_ok[NBR_SOUTH] = (DIM_W'(tile_y) + DIM_W'(1)) < cfg.grid_height;
      cls.nbr_ok[NBR_NORTH] = tile_y != '0;
      // drop the unused command and tiles outside the grid in use
      cls_ok = (cmd == CMD_LOAD || cmd == CMD_INIT || cmd == CMD_UPDATE)
               && (DIM_W'(tile_x) < cfg.grid_width)
               && (DIM_W'(tile_y) < cfg.grid_height);
   end

   assign full       = count_ff == 2'(Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = q_ff[rd_ptr_ff];
   assign enq        = push & ~full & cls_ok;
   assign deq        = head_pop & head_valid;

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(enq) - 2'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ design/dtsu_back.sv @@
// Back end: sequencer over the density and target stores that executes queued items
`timescale 1ns / 1ps
module dtsu_back import dtsu_pkg::*; #(
   parameter int GRID_X_MAX = GRID_X_MAX_DEF,
   parameter int GRID_Y_MAX = GRID_Y_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  item_type          head,
   input  logic              head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [TILE_W-1:0] rsp_out_x,
   output logic [TILE_W-1:0] rsp_out_y,
   output logic [VAL_W-1:0]  rsp_new_target,
   output logic              rsp_raised
);

   localparam int DEPTH = GRID_X_MAX * GRID_Y_MAX;
   localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_INIT   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_LAST   = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   // read steps: own tile first, then the four neighbors
   localparam logic [2:0] STEP_HERE  = 3'd0;
   localparam logic [2:0] STEP_EAST  = 3'd1;
   localparam logic [2:0] STEP_WEST  = 3'd2;
   localparam logic [2:0] STEP_SOUTH = 3'd3;
   localparam logic [2:0] STEP_NORTH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       step_ff, step_in;
   logic             rd_vld_ff;
   logic [2:0]       rd_step_ff;
   item_type         work_ff, work_in;
   logic [SUM_W-1:0] here_lim_ff, here_lim_in;
   logic [VAL_W-1:0] cur_ff, cur_in;
   logic [SUM_W-1:0] need_ff, need_in;

   logic              rsp_vld_ff, rsp_vld_in;
   logic [TILE_W-1:0] rsp_x_ff;
   logic [TILE_W-1:0] rsp_y_ff;
   logic [VAL_W-1:0]  rsp_target_ff;
   logic              rsp_raised_ff;

   logic [AW-1:0]    idx;
   logic [AW-1:0]    den_rd_addr;
   logic [VAL_W-1:0] den_rd_data;
   logic [VAL_W-1:0] tgt_rd_data;
   logic             den_wr_en;
   logic             tgt_wr_en;
   logic [VAL_W-1:0] tgt_wr_data;

   logic             nbr_hit;
   logic             viol;
   logic [SUM_W-1:0] cand;
   logic [VAL_W-1:0] capped;
   logic             raise;
   logic             slot_free;
   logic             finish;

   assign idx = AW'(int'(work_ff.tile_y) * GRID_X_MAX + int'(work_ff.tile_x));

   always_comb begin
      case (step_ff)
         STEP_EAST:  den_rd_addr = work_ff.nbr_ok[NBR_EAST]  ? idx + AW'(1) : idx;
         STEP_WEST:  den_rd_addr = work_ff.nbr_ok[NBR_WEST]  ? idx - AW'(1) : idx;
         STEP_SOUTH: den_rd_addr = work_ff.nbr_ok[NBR_SOUTH] ? idx + AW'(GRID_X_MAX) : idx;
         STEP_NORTH: den_rd_addr = work_ff.nbr_ok[NBR_NORTH] ? idx - AW'(GRID_X_MAX) : idx;
         default:    den_rd_addr = idx;
      endcase
   end

   // fold in the density that arrives from the previous read step
   always_comb begin
      case (rd_step_ff)
         STEP_EAST:  nbr_hit = work_ff.nbr_ok[NBR_EAST];
         STEP_WEST:  nbr_hit = work_ff.nbr_ok[NBR_WEST];
         STEP_SOUTH: nbr_hit = work_ff.nbr_ok[NBR_SOUTH];
         STEP_NORTH: nbr_hit = work_ff.nbr_ok[NBR_NORTH];
         default:    nbr_hit = 1'b0;
      endcase
      cand = SUM_W'(den_rd_data) + SUM_W'(cfg.gradient_headroom) - SUM_W'(cfg.step_limit);
      viol = (cfg.step_limit != '0) && nbr_hit && (SUM_W'(den_rd_data) > here_lim_ff);
      here_lim_in = here_lim_ff;
      cur_in      = cur_ff;
      need_in     = need_ff;
      if (rd_vld_ff) begin
         if (rd_step_ff == STEP_HERE) begin
            cur_in      = tgt_rd_data;
            here_lim_in = SUM_W'(den_rd_data) + SUM_W'(cfg.step_limit);
            need_in     = SUM_W'(tgt_rd_data);
            if (den_rd_data < cfg.dens_floor && cfg.floor_target > tgt_rd_data) begin
               need_in = SUM_W'(cfg.floor_target);
            end
         end else if (viol && cand > need_ff) begin
            need_in = cand;
         end
      end
   end

   always_comb begin
      capped    = (need_ff > SUM_W'(cfg.dens_cap)) ? cfg.dens_cap : need_ff[VAL_W-1:0];
      raise     = capped > cur_ff;
      slot_free = ~rsp_vld_ff | rsp_pop;
      finish    = (state_ff == ST_DECIDE) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      head_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               work_in  = head;
               step_in  = STEP_HERE;
               unique case (head.cmd)
                  CMD_LOAD: state_in = ST_LOAD;
                  CMD_INIT: state_in = ST_INIT;
                  default:  state_in = ST_READ;
               endcase
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_INIT: state_in = ST_IDLE;
         ST_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_NORTH) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_DECIDE;
         ST_DECIDE: begin
            // hold until the result register is free
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign den_wr_en   = state_ff == ST_LOAD;
   assign tgt_wr_en   = (state_ff == ST_INIT) | (finish & raise);
   assign tgt_wr_data = (state_ff == ST_INIT) ? cfg.floor_target : capped;
   assign rsp_vld_in  = finish | (rsp_vld_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= STEP_HERE;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         rd_vld_ff  <= state_ff == ST_READ;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff  <= step_ff;
      work_ff     <= work_in;
      here_lim_ff <= here_lim_in;
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      if (finish) begin
         rsp_x_ff      <= work_ff.tile_x;
         rsp_y_ff      <= work_ff.tile_y;
         rsp_target_ff <= raise ? capped : cur_ff;
         rsp_raised_ff <= raise;
      end
   end

   dtsu_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_density_ram (
      .clock   (clock),
      .wr_en   (den_wr_en),
      .wr_addr (idx),
      .wr_data (work_ff.density),
      .rd_addr (den_rd_addr),
      .rd_data (den_rd_data)
   );

   dtsu_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_target_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (idx),
      .wr_data (tgt_wr_data),
      .rd_addr (idx),
      .rd_data (tgt_rd_data)
   );

   assign rsp_empty      = ~rsp_vld_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_new_target = rsp_target_ff;
   assign rsp_raised     = rsp_raised_ff;

endmodule

@@ design/density_target_stencil_update.sv @@
// Top level of the density target stencil update block
//
//   Channel   Ports                                       Beat taken when
//   request   push/full, req_cmd, req_tile_*, req_density push & !full
//   result    empty/pop, rsp_out_*, rsp_new_target, raised pop & !empty
//   config    psel/penable/pwrite/paddr/pwdata/prdata     psel & penable & pwrite & pready
//
// Load and init: dispatch, then the store write. Update: dispatch, five reads of the
// density store through its one read port (own tile, then four neighbors), a wait for
// the last read data, and the decision with target write-back when the result reg is free.
// A 2-entry queue sits between front and back; the result register holds a beat until
// popped while the front keeps accepting. Synchronous reset clears control only; both
// stores keep no reset; the user reads them only after writing, the block does not check.
`timescale 1ns / 1ps
module density_target_stencil_update import dtsu_pkg::*; #(
   parameter int GRID_X_MAX = GRID_X_MAX_DEF,
   parameter int GRID_Y_MAX = GRID_Y_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [TILE_W-1:0]     req_tile_x,
   input  logic [TILE_W-1:0]     req_tile_y,
   input  logic [VAL_W-1:0]      req_density_in,
   output logic                  empty,
   input  logic                  pop,
   output logic [TILE_W-1:0]     rsp_out_x,
   output logic [TILE_W-1:0]     rsp_out_y,
   output logic [VAL_W-1:0]      rsp_new_target,
   output logic                  rsp_raised,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   item_type head;
   logic     head_valid;
   logic     head_pop;

   dtsu_csr #(
      .GRID_X_MAX (GRID_X_MAX),
      .GRID_Y_MAX (GRID_Y_MAX)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .cmd        (req_cmd),
      .tile_x     (req_tile_x),
      .tile_y     (req_tile_y),
      .density_in (req_density_in),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   dtsu_back #(
      .GRID_X_MAX (GRID_X_MAX),
      .GRID_Y_MAX (GRID_Y_MAX)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head           (head),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .rsp_empty      (empty),
      .rsp_pop        (pop),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_new_target (rsp_new_target),
      .rsp_raised     (rsp_raised)
   );

endmodule

@@ design/dtsu_checker.sv @@
// Port-level checker for the density target stencil update block, with its bind
`timescale 1ns / 1ps
module dtsu_checker import dtsu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  push,
   input logic                  full,
   input logic                  empty,
   input logic                  pop,
   input logic [TILE_W-1:0]     rsp_out_x,
   input logic [TILE_W-1:0]     rsp_out_y,
   input logic [VAL_W-1:0]      rsp_new_target,
   input logic                  rsp_raised
);

   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("request queue filled without a push");

   a_raised_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_raised |-> rsp_new_target != '0 && rsp_new_target <= ONE)
      else $error("raised target outside the capped range");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_x) && $stable(rsp_out_y)
                         && $stable(rsp_new_target) && $stable(rsp_raised))
      else $error("waiting result changed before pop");

endmodule

bind density_target_stencil_update dtsu_checker u_checker (.*);

@@ test/tb_density_target_stencil_update.sv @@
// Self-checking testbench for the density target stencil update block
`timescale 1ns / 1ps
module tb_density_target_stencil_update import dtsu_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int DEPTH         = GRID_X_MAX_DEF * GRID_Y_MAX_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES  = 800000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TILE_W-1:0] tile_x;
      logic [TILE_W-1:0] tile_y;
      logic [VAL_W-1:0]  density;
   } req_beat_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_x;
      logic [TILE_W-1:0] tile_y;
      logic [VAL_W-1:0]  target;
      logic              raised;
   } rsp_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [TILE_W-1:0]     req_tile_x = '0;
   logic [TILE_W-1:0]     req_tile_y = '0;
   logic [VAL_W-1:0]      req_density_in = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [TILE_W-1:0]     rsp_out_x;
   logic [TILE_W-1:0]     rsp_out_y;
   logic [VAL_W-1:0]      rsp_new_target;
   logic                  rsp_raised;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   density_target_stencil_update u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_tile_x     (req_tile_x),
      .req_tile_y     (req_tile_y),
      .req_density_in (req_density_in),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_new_target (rsp_new_target),
      .rsp_raised     (rsp_raised),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // predictor state
   logic [VAL_W-1:0] cfg_raw [REG_GRID_HEIGHT+1];
   logic [VAL_W-1:0] density_mem [DEPTH];
   logic [VAL_W-1:0] target_mem [DEPTH];

   // stimulus bookkeeping: which entries have been written so far
   bit dens_seen [DEPTH];
   bit targ_seen [DEPTH];
   int walk_x = 0;
   int walk_y = 0;
   int live_items = 0;

   req_beat_type req_backlog [$];
   rsp_beat_type due_targets [$];
   bit           req_taken = 1'b0;
   bit           drain_hold = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           starts = 0;
   logic [15:0]  pop_pat = '1;
   int           pop_left = 0;
   int unsigned  cycle_count = 0;
   int           mismatch_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [VAL_W-1:0] clip_one(input logic [VAL_W-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   function automatic int grid_span(input logic [VAL_W-1:0] v);
      int d;
      d = int'(v[DIM_W-1:0]);
      if (d < 1) d = 1;
      if (d > GRID_X_MAX_DEF) d = GRID_X_MAX_DEF;
      return d;
   endfunction

   function automatic int floor_target();
      int b;
      int cap;
      b = int'(clip_one(cfg_raw[REG_DENS_FLOOR]))
          + int'(clip_one(cfg_raw[REG_FILL_MARGIN]));
      cap = int'(clip_one(cfg_raw[REG_DENS_CAP]));
      return (b < cap) ? b : cap;
   endfunction

   // Apply one accepted request to the predicted stores; return 1 when it yields a beat.
   function automatic bit predict_target_update(input req_beat_type r,
                                                output rsp_beat_type res);
      int gw, gh, idx, here, cur, want, cap, grad, nx, ny, nd, cand;
      gw = grid_span(cfg_raw[REG_GRID_WIDTH]);
      gh = grid_span(cfg_raw[REG_GRID_HEIGHT]);
      res = '0;
      if (r.cmd == CMD_UNUSED || int'(r.tile_x) >= gw || int'(r.tile_y) >= gh) return 0;
      idx = int'(r.tile_y) * GRID_X_MAX_DEF + int'(r.tile_x);
      if (r.cmd == CMD_LOAD) begin
         density_mem[idx] = clip_one(r.density);
         return 0;
      end
      if (r.cmd == CMD_INIT) begin
         target_mem[idx] = VAL_W'(floor_target());
         return 0;
      end
      here = int'(density_mem[idx]);
      cur = int'(target_mem[idx]);
      want = cur;
      cap = int'(clip_one(cfg_raw[REG_DENS_CAP]));
      grad = int'(clip_one(cfg_raw[REG_STEP_LIMIT]));
      if (here < int'(clip_one(cfg_raw[REG_DENS_FLOOR])) && floor_target() > want)
         want = floor_target();
      if (grad > 0) begin
         for (int k = 0; k < NBR_N; k++) begin
            nx = int'(r.tile_x);
            ny = int'(r.tile_y);
            case (k)
               NBR_EAST:  nx = nx + 1;
               NBR_WEST:  nx = nx - 1;
               NBR_SOUTH: ny = ny + 1;
               default:   ny = ny - 1;
            endcase
            if (nx >= 0 && ny >= 0 && nx < gw && ny < gh) begin
               nd = int'(density_mem[ny * GRID_X_MAX_DEF + nx]);
               if (nd - here > grad) begin
                  cand = nd - grad + int'(clip_one(cfg_raw[REG_GRADIENT_HEADROOM]));
                  if (cand > want) want = cand;
               end
            end
         end
      end
      if (want > cap) want = cap;
      res.raised = (want > cur);
      if (res.raised) begin
         target_mem[idx] = want[VAL_W-1:0];
         cur = want;
      end
      res.tile_x = r.tile_x;
      res.tile_y = r.tile_y;
      res.target = cur[VAL_W-1:0];
      return 1;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // ---------------- stimulus generation ----------------

   function automatic logic [VAL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ONE;
         2: return VAL_W'($urandom_range(int'(ONE) + 1, (1 << VAL_W) - 1));
         default: return VAL_W'($urandom_range(0, int'(ONE)));
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_density();
      int m;
      case ($urandom_range(0, 5))
         4: return VAL_W'($urandom_range(0, 'h1800));
         5: begin
            // land on or next to the density floor
            m = int'(clip_one(cfg_raw[REG_DENS_FLOOR])) + int'($urandom_range(0, 8)) - 4;
            if (m < 0) m = 0;
            return VAL_W'(m);
         end
         default: return pick_level();
      endcase
   endfunction

   function automatic void queue_item(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                      input logic [VAL_W-1:0] dens);
      req_beat_type r;
      int idx;
      r.cmd = cmd;
      r.tile_x = TILE_W'(x);
      r.tile_y = TILE_W'(y);
      r.density = dens;
      req_backlog.insert(req_backlog.size(), r);
      idx = int'(r.tile_y) * GRID_X_MAX_DEF + int'(r.tile_x);
      if (cmd != CMD_UNUSED && int'(r.tile_x) < grid_span(cfg_raw[REG_GRID_WIDTH])
          && int'(r.tile_y) < grid_span(cfg_raw[REG_GRID_HEIGHT])) begin
         live_items++;
         if (cmd == CMD_LOAD) dens_seen[idx] = 1'b1;
         if (cmd == CMD_INIT) targ_seen[idx] = 1'b1;
      end
   endfunction

   // Load and init whatever the update will read that is still unwritten, then issue the update.
   function automatic void prep_and_update(input int x, input int y, input bit fresh);
      int gw, gh, nx, ny;
      gw = grid_span(cfg_raw[REG_GRID_WIDTH]);
      gh = grid_span(cfg_raw[REG_GRID_HEIGHT]);
      for (int k = 0; k <= NBR_N; k++) begin
         nx = x;
         ny = y;
         case (k)
            NBR_EAST:  nx = x + 1;
            NBR_WEST:  nx = x - 1;
            NBR_SOUTH: ny = y + 1;
            NBR_NORTH: ny = y - 1;
            default: ;
         endcase
         if (nx >= 0 && ny >= 0 && nx < gw && ny < gh)
            if (!dens_seen[ny * GRID_X_MAX_DEF + nx] || (fresh && $urandom_range(0, 1)))
               queue_item(CMD_LOAD, nx, ny, pick_density());
      end
      if (!targ_seen[y * GRID_X_MAX_DEF + x] || $urandom_range(0, 3) == 0)
         queue_item(CMD_INIT, x, y, VAL_W'($urandom));
      queue_item(CMD_UPDATE, x, y, VAL_W'($urandom));
   endfunction

   function automatic void pick_tile(output int x, output int y);
      int gw, gh;
      gw = grid_span(cfg_raw[REG_GRID_WIDTH]);
      gh = grid_span(cfg_raw[REG_GRID_HEIGHT]);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            walk_x = walk_x + int'($urandom_range(0, 2)) - 1;
            walk_y = walk_y + int'($urandom_range(0, 2)) - 1;
         end
         4, 5, 6: begin
            walk_x = $urandom_range(0, gw - 1);
            walk_y = $urandom_range(0, gh - 1);
         end
         default: begin
            // hug an edge of the grid
            walk_x = $urandom_range(0, 1) ? 0 : gw - 1;
            walk_y = $urandom_range(0, gh - 1);
            if ($urandom_range(0, 1)) begin
               walk_x = $urandom_range(0, gw - 1);
               walk_y = $urandom_range(0, 1) ? 0 : gh - 1;
            end
         end
      endcase
      if (walk_x < 0) walk_x = 0;
      if (walk_x > gw - 1) walk_x = gw - 1;
      if (walk_y < 0) walk_y = 0;
      if (walk_y > gh - 1) walk_y = gh - 1;
      x = walk_x;
      y = walk_y;
   endfunction

   function automatic void gen_random_step();
      int x, y, gw, gh;
      logic [CMD_W-1:0] nc;
      gw = grid_span(cfg_raw[REG_GRID_WIDTH]);
      gh = grid_span(cfg_raw[REG_GRID_HEIGHT]);
      pick_tile(x, y);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            prep_and_update(x, y, 1'b1);
            if ($urandom_range(0, 3) == 0) queue_item(CMD_UPDATE, x, y, VAL_W'($urandom));
         end
         5, 6: queue_item(CMD_LOAD, x, y, pick_density());
         7: queue_item(CMD_INIT, x, y, VAL_W'($urandom));
         8: begin
            // junk the block must drop: off-grid tile or the spare command
            nc = CMD_W'($urandom_range(0, 3));
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            if (gw < GRID_X_MAX_DEF && $urandom_range(0, 1)) x = $urandom_range(gw, 63);
            else if (gh < GRID_Y_MAX_DEF) y = $urandom_range(gh, 63);
            else nc = CMD_UNUSED;
            queue_item(nc, x, y, VAL_W'($urandom));
         end
         default: prep_and_update(x, y, 1'b0);
      endcase
   endfunction

   function automatic void run_random(input int n);
      int stop_at;
      stop_at = live_items + n;
      while (live_items < stop_at) gen_random_step();
   endfunction

   // ---------------- configuration and sequencing ----------------

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_GRID_WIDTH || idx == REG_GRID_HEIGHT) cfg_raw[idx] = VAL_W'(value[DIM_W-1:0]);
      else cfg_raw[idx] = value[VAL_W-1:0];
   endtask

   task automatic set_config(input logic [VAL_W-1:0] mn, input logic [VAL_W-1:0] mx,
                             input logic [VAL_W-1:0] grad, input logic [VAL_W-1:0] fill,
                             input logic [VAL_W-1:0] ghead, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
      logic [VAL_W-1:0] vals [REG_GRID_HEIGHT+1];
      logic [CSR_DATA_W-1:0] word;
      vals[REG_DENS_FLOOR] = mn;
      vals[REG_DENS_CAP] = mx;
      vals[REG_STEP_LIMIT] = grad;
      vals[REG_FILL_MARGIN] = fill;
      vals[REG_GRADIENT_HEADROOM] = ghead;
      vals[REG_GRID_WIDTH] = VAL_W'(w);
      vals[REG_GRID_HEIGHT] = VAL_W'(h);
      for (int i = 0; i <= REG_GRID_HEIGHT; i++) begin
         // junk in the unused upper bits half of the time
         word = $urandom_range(0, 1) ? $urandom : '0;
         if (i == REG_GRID_WIDTH || i == REG_GRID_HEIGHT) word[DIM_W-1:0] = vals[i][DIM_W-1:0];
         else word[VAL_W-1:0] = vals[i];
         csr_write(REG_IDX_W'(i), word);
      end
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || push || due_targets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : sequencer
      logic [VAL_W-1:0] grad;
      logic [DIM_W-1:0] w, h;
      cfg_raw[REG_DENS_FLOOR] = '0;
      cfg_raw[REG_DENS_CAP] = ONE;
      cfg_raw[REG_STEP_LIMIT] = '0;
      cfg_raw[REG_FILL_MARGIN] = '0;
      cfg_raw[REG_GRADIENT_HEADROOM] = '0;
      cfg_raw[REG_GRID_WIDTH] = VAL_W'(GRID_X_MAX_DEF);
      cfg_raw[REG_GRID_HEIGHT] = VAL_W'(GRID_Y_MAX_DEF);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // settings out of reset: far corner, origin, spare command
      queue_item(CMD_LOAD, 63, 63, '1);
      prep_and_update(63, 63, 1'b0);
      prep_and_update(0, 0, 1'b0);
      queue_item(CMD_UNUSED, 0, 0, '0);
      wait_idle();

      // small 3x2 grid with hand-picked densities
      set_config(17'h04000, 17'h0C000, 17'h01000, 17'h02000, 17'h00800, 7'd3, 7'd2);
      queue_item(CMD_LOAD, 0, 0, 17'h00000);
      queue_item(CMD_LOAD, 1, 0, 17'h1FFFF);
      queue_item(CMD_LOAD, 2, 0, 17'h10000);
      queue_item(CMD_LOAD, 0, 1, 17'h01000);   // step to the origin equals the gradient
      queue_item(CMD_LOAD, 1, 1, 17'h08000);
      queue_item(CMD_LOAD, 2, 1, 17'h04000);   // exactly at the floor
      for (int y = 0; y < 2; y++)
         for (int x = 0; x < 3; x++) queue_item(CMD_INIT, x, y, '0);
      queue_item(CMD_UPDATE, 0, 0, '0);
      queue_item(CMD_UPDATE, 0, 0, '1);
      queue_item(CMD_UPDATE, 2, 1, '0);
      queue_item(CMD_UPDATE, 1, 1, '0);
      queue_item(CMD_UPDATE, 2, 0, '0);
      queue_item(CMD_LOAD, 5, 0, 17'h0ABCD);
      queue_item(CMD_LOAD, 0, 5, 17'h0ABCD);
      queue_item(CMD_UNUSED, 1, 1, '1);
      queue_item(CMD_UPDATE, 63, 63, '0);
      wait_idle();

      // cap drops below targets already stored
      set_config(17'h04000, 17'h02000, 17'h01000, 17'h02000, 17'h00800, 7'd3, 7'd2);
      queue_item(CMD_UPDATE, 0, 0, '0);
      queue_item(CMD_UPDATE, 1, 0, '0);
      run_random(60);
      wait_idle();

      set_config('0, '0, 17'h00001, '0, '0, 7'd1, 7'd1);
      run_random(40);
      wait_idle();

      set_config('1, '1, '1, '1, '1, 7'd0, 7'd127);
      run_random(80);
      wait_idle();

      set_config(17'h03000, 17'h0E000, 17'h00800, 17'h01000, 17'h00400, 7'd64, 7'd64);
      run_random(150);
      wait_idle();

      repeat (6) begin
         case ($urandom_range(0, 3))
            0: grad = '0;
            3: grad = pick_level();
            default: grad = VAL_W'($urandom_range(1, 'h3000));
         endcase
         w = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 127))
                                         : DIM_W'($urandom_range(1, 8));
         h = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 127))
                                         : DIM_W'($urandom_range(1, 8));
         set_config(pick_level(), pick_level(), grad, pick_level(),
                    VAL_W'($urandom_range(0, 'h4000)), w, h);
         run_random(70);
         wait_idle();
      end

      if (mismatch_count == 0 && due_targets.size() == 0)
         $display("density_target_stencil_update regression: pass");
      else
         $display("density_target_stencil_update regression: fail");
      $finish;
   end

   // ---------------- driver ----------------

   always @(negedge clock) begin : driver
      req_beat_type nxt;
      logic [15:0] p;
      bit go;
      if (reset) begin
         push <= 1'b0;
         pop <= 1'b0;
      end else begin
         // receiver: pick a fresh 16-bit stall pattern when the last one runs out
         p = pop_pat;
         if (pop_left == 0) begin
            case ($urandom_range(0, 3))
               0: p = '1;
               1: p = 16'($urandom);
               2: p = 16'($urandom & $urandom & $urandom);
               default: p = 16'h0001;
            endcase
            pop_left = 16;
         end
         pop <= p[0];
         pop_pat = {p[0], p[15:1]};
         pop_left = pop_left - 1;

         // sender: hold an unaccepted beat, else maybe start the next one
         go = push && !req_taken;
         req_taken = 1'b0;
         if (!go) begin
            if (drain_hold && due_targets.size() == 0) drain_hold = 1'b0;
            if (!drain_hold && starts % 173 == 100 && due_targets.size() != 0)
               drain_hold = 1'b1;
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (!drain_hold && req_backlog.size() != 0) begin
               nxt = req_backlog.pop_front();
               req_cmd <= nxt.cmd;
               req_tile_x <= nxt.tile_x;
               req_tile_y <= nxt.tile_y;
               req_density_in <= nxt.density;
               go = 1'b1;
               starts++;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
         push <= go;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : monitor
      req_beat_type r;
      rsp_beat_type want;
      rsp_beat_type got;
      if (!reset) begin
         if (push && !full) begin
            r.cmd = req_cmd;
            r.tile_x = req_tile_x;
            r.tile_y = req_tile_y;
            r.density = req_density_in;
            if (predict_target_update(r, want)) due_targets.insert(due_targets.size(), want);
            req_taken = 1'b1;
         end
         if (pop && !empty) begin
            got.tile_x = rsp_out_x;
            got.tile_y = rsp_out_y;
            got.target = rsp_new_target;
            got.raised = rsp_raised;
            if (due_targets.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat tile (%0d,%0d) target %0h",
                                       got.tile_x, got.tile_y, got.target));
            end else begin
               want = due_targets.pop_front();
               if (got.tile_x != want.tile_x)
                  flag_mismatch($sformatf("out_x %0d, predicted %0d", got.tile_x, want.tile_x));
               if (got.tile_y != want.tile_y)
                  flag_mismatch($sformatf("out_y %0d, predicted %0d", got.tile_y, want.tile_y));
               if (got.target != want.target)
                  flag_mismatch($sformatf("new_target %0h, predicted %0h at (%0d,%0d)",
                                          got.target, want.target, want.tile_x, want.tile_y));
               if (got.raised != want.raised)
                  flag_mismatch($sformatf("raised %0d, predicted %0d at (%0d,%0d)",
                                          got.raised, want.raised, want.tile_x, want.tile_y));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("density_target_stencil_update regression: fail");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
design/dtsu_pkg.sv
design/dtsu_ram.sv
design/dtsu_csr.sv
design/dtsu_front.sv
design/dtsu_back.sv
design/density_target_stencil_update.sv
design/dtsu_checker.sv
test/tb_density_target_stencil_update.sv
